/* rtl/assert_macros.svh */
// Assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/mwo_pkg.sv */
package mwo_pkg;

    localparam int ENC_W     = 13;
    localparam int POS_W     = 48;
    localparam int ANG_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int COUNTS_PER_REV = 8192;
    localparam int CORDIC_STEPS   = 16;

    // deltas and wheel sums, +/-16384 at most
    localparam int DELTA_W = 16;
    localparam logic signed [DELTA_W-1:0] HALF_REV = DELTA_W'(COUNTS_PER_REV / 2);
    localparam logic signed [DELTA_W-1:0] FULL_REV = DELTA_W'(COUNTS_PER_REV);

    localparam int VEC_W    = 32;
    localparam int CRD_W    = 34;
    localparam int KIN_P_W  = 48;
    localparam int GAIN_W   = 30;
    localparam int GAIN_P_W = 64;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW  = 1'b1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DELTA, ST_SUM, ST_KIN, ST_ROT, ST_GAIN, ST_DONE
    } t_state;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/mwo_sermul.sv */
// shift-add multiplier, one multiplier bit per cycle
module mwo_sermul #(
    parameter int A_W      = 33,
    parameter int B_W      = 16,
    parameter int P_W      = 48,
    parameter bit B_SIGNED = 1'b1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [A_W-1:0] i_a,
    input  logic        [B_W-1:0] i_b,
    output logic                  o_done,
    output logic signed [P_W-1:0] o_p
);
    localparam int CNT_W = $clog2(B_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [P_W-1:0] r_mcand;
    logic [B_W-1:0]        r_mplier;
    logic signed [P_W-1:0] r_acc;
    logic                  last;

    assign last = (r_cnt == CNT_W'(B_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= {{(P_W-A_W){i_a[A_W-1]}}, i_a};
            r_mplier <= i_b;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                if (B_SIGNED && last) begin
                    r_acc <= r_acc - r_mcand;
                end else begin
                    r_acc <= r_acc + r_mcand;
                end
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

/* rtl/mwo_cordic.sv */
// rotation-mode CORDIC, one micro-rotation per cycle
module mwo_cordic #(
    parameter int STEPS = mwo_pkg::CORDIC_STEPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [mwo_pkg::VEC_W-1:0]      i_x,
    input  logic signed [mwo_pkg::VEC_W-1:0]      i_y,
    input  logic        [mwo_pkg::ANG_W-1:0]      i_h,
    output logic                                  o_done,
    output logic signed [mwo_pkg::CRD_W-1:0]      o_x,
    output logic signed [mwo_pkg::CRD_W-1:0]      o_y
);
    localparam int CNT_W = $clog2(STEPS);
    localparam int W     = mwo_pkg::CRD_W;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_i;
    logic signed [W-1:0]  r_x, r_y, r_z;
    logic signed [W-1:0]  xs, ys, xe, ye, at;
    logic [mwo_pkg::ANG_W-1:0] h_f;
    logic                 fold;

    // left half-plane: negate vector, turn angle by pi
    assign fold = (i_h[31:30] == 2'b01) || (i_h[31:30] == 2'b10);
    assign h_f  = {i_h[31] ^ fold, i_h[30:0]};
    assign xe   = {{(W-mwo_pkg::VEC_W){i_x[mwo_pkg::VEC_W-1]}}, i_x};
    assign ye   = {{(W-mwo_pkg::VEC_W){i_y[mwo_pkg::VEC_W-1]}}, i_y};
    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = {2'b00, mwo_pkg::atan_turn(5'(r_i))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= fold ? -xe : xe;
            r_y <= fold ? -ye : ye;
            r_z <= {{(W-mwo_pkg::ANG_W){h_f[31]}}, h_f};
        end else if (r_busy) begin
            if (!r_z[W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

/* rtl/mecanum_wheel_odometry_top.sv */
// Mecanum odometry top level.
// An update word passes ST_DELTA, ST_SUM, the bit-serial wheel multipliers (ST_KIN),
// the CORDIC_STEPS iterations of the rotator (ST_ROT) and the gain multipliers (ST_GAIN)
// to ST_DONE; a capture word goes straight to ST_DONE. Either waits there while the
// previous result is stalled. No new word is taken until the result is registered.
// Reset (synchronous, active low) clears pose, last counts, registers and valids.
`include "assert_macros.svh"
module mecanum_wheel_odometry_top #(
    parameter int CORDIC_STEPS = mwo_pkg::CORDIC_STEPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config port
    input  logic                                 i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mwo_pkg::CFG_W-1:0]            i_cfg_data,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic [mwo_pkg::ENC_W-1:0]            i_enc_front_left,
    input  logic [mwo_pkg::ENC_W-1:0]            i_enc_front_right,
    input  logic [mwo_pkg::ENC_W-1:0]            i_enc_rear_left,
    input  logic [mwo_pkg::ENC_W-1:0]            i_enc_rear_right,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mwo_pkg::POS_W-1:0]     o_x_position,
    output logic signed [mwo_pkg::POS_W-1:0]     o_y_position,
    output logic signed [mwo_pkg::ANG_W-1:0]     o_heading_angle
);
    localparam int DW = mwo_pkg::DELTA_W;
    localparam int PW = mwo_pkg::POS_W;

    mwo_pkg::t_state r_state, n_state;

    logic [mwo_pkg::CFG_W-1:0]  r_dist, r_yaw;
    logic [mwo_pkg::ENC_W-1:0]  r_c    [4];
    logic [mwo_pkg::ENC_W-1:0]  r_last [4];
    logic signed [DW-1:0]       r_d    [4];
    logic signed [DW-1:0]       r_sx, r_sy, r_sw;
    logic [PW-1:0]              r_pos_x, r_pos_y;
    logic [mwo_pkg::ANG_W-1:0]  r_head;
    logic                       r_out_valid;
    logic [PW-1:0]              r_ox, r_oy;
    logic [mwo_pkg::ANG_W-1:0]  r_oh;
    logic                       r_kin_go;

    logic in_acc, out_free;
    logic kin_done_x, kin_done_y, kin_done_w;
    logic signed [mwo_pkg::KIN_P_W-1:0] kin_px, kin_py, kin_pw;
    logic rot_done;
    logic signed [mwo_pkg::CRD_W-1:0] rot_x, rot_y;
    logic gain_done_x, gain_done_y;
    logic signed [mwo_pkg::GAIN_P_W-1:0] gain_px, gain_py;
    logic [PW-1:0] gx, gy;

    // count delta wrapped to half a revolution
    function automatic logic signed [DW-1:0] wrap_delta(
        input logic [mwo_pkg::ENC_W-1:0] now_c,
        input logic [mwo_pkg::ENC_W-1:0] prev_c
    );
        logic signed [DW-1:0] d;
        d = signed'(DW'(now_c)) - signed'(DW'(prev_c));
        if (d > mwo_pkg::HALF_REV) begin
            d = d - mwo_pkg::FULL_REV;
        end else if (d < -mwo_pkg::HALF_REV) begin
            d = d + mwo_pkg::FULL_REV;
        end
        return d;
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != mwo_pkg::ST_IDLE);

    // sequencer; r_kin_go marks the first ST_KIN cycle, when the wheel sums are ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mwo_pkg::ST_IDLE;
            r_kin_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kin_go <= (r_state == mwo_pkg::ST_SUM);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mwo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_operation == mwo_pkg::OP_UPDATE) ?
                              mwo_pkg::ST_DELTA : mwo_pkg::ST_DONE;
                end
            end
            mwo_pkg::ST_DELTA: n_state = mwo_pkg::ST_SUM;
            mwo_pkg::ST_SUM:   n_state = mwo_pkg::ST_KIN;
            mwo_pkg::ST_KIN:   if (kin_done_x)  n_state = mwo_pkg::ST_ROT;
            mwo_pkg::ST_ROT:   if (rot_done)    n_state = mwo_pkg::ST_GAIN;
            mwo_pkg::ST_GAIN:  if (gain_done_x) n_state = mwo_pkg::ST_DONE;
            mwo_pkg::ST_DONE:  if (out_free)    n_state = mwo_pkg::ST_IDLE;
            default:           n_state = mwo_pkg::ST_IDLE;
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_yaw  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwo_pkg::CFG_DIST: r_dist <= i_cfg_data;
                mwo_pkg::CFG_YAW:  r_yaw  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Q16.16 product into Q32.16 step, sign-extended
    assign gx = {{(PW-32){gain_px[63]}}, gain_px[63:32]};
    assign gy = {{(PW-32){gain_py[63]}}, gain_py[63:32]};

    // pose and encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_last[k] <= '0;
            end
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head  <= '0;
        end else begin
            if (in_acc && i_operation == mwo_pkg::OP_CAPTURE) begin
                r_last[0] <= i_enc_front_left;
                r_last[1] <= i_enc_front_right;
                r_last[2] <= i_enc_rear_left;
                r_last[3] <= i_enc_rear_right;
                r_pos_x   <= '0;
                r_pos_y   <= '0;
                r_head    <= '0;
            end
            if (r_state == mwo_pkg::ST_DELTA) begin
                for (int k = 0; k < 4; k++) begin
                    r_last[k] <= r_c[k];
                end
            end
            if (r_state == mwo_pkg::ST_GAIN && gain_done_x) begin
                r_pos_x <= r_pos_x + gx;
                r_pos_y <= r_pos_y + gy;
                r_head  <= r_head + kin_pw[47:16];
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_c[0] <= i_enc_front_left;
            r_c[1] <= i_enc_front_right;
            r_c[2] <= i_enc_rear_left;
            r_c[3] <= i_enc_rear_right;
        end
        if (r_state == mwo_pkg::ST_DELTA) begin
            for (int k = 0; k < 4; k++) begin
                r_d[k] <= wrap_delta(r_c[k], r_last[k]);
            end
        end
        if (r_state == mwo_pkg::ST_SUM) begin
            r_sx <=  r_d[0] + r_d[1] + r_d[2] + r_d[3];
            r_sy <= -r_d[0] + r_d[1] + r_d[2] - r_d[3];
            r_sw <= -r_d[0] + r_d[1] - r_d[2] + r_d[3];
        end
    end

    // wheel sums times gains; start on the first ST_KIN cycle
    mwo_sermul #(.A_W(33), .B_W(DW), .P_W(mwo_pkg::KIN_P_W), .B_SIGNED(1'b1)) u_kin_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_kin_go),
        .i_a({1'b0, r_dist}), .i_b(r_sx), .o_done(kin_done_x), .o_p(kin_px)
    );
    mwo_sermul #(.A_W(33), .B_W(DW), .P_W(mwo_pkg::KIN_P_W), .B_SIGNED(1'b1)) u_kin_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_kin_go),
        .i_a({1'b0, r_dist}), .i_b(r_sy), .o_done(kin_done_y), .o_p(kin_py)
    );
    mwo_sermul #(.A_W(33), .B_W(DW), .P_W(mwo_pkg::KIN_P_W), .B_SIGNED(1'b1)) u_kin_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_kin_go),
        .i_a({1'b0, r_yaw}), .i_b(r_sw), .o_done(kin_done_w), .o_p(kin_pw)
    );

    // rotate local step by the heading held before this update
    mwo_cordic #(.STEPS(CORDIC_STEPS)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == mwo_pkg::ST_KIN && kin_done_x),
        .i_x(kin_px[47:16]), .i_y(kin_py[47:16]), .i_h(r_head),
        .o_done(rot_done), .o_x(rot_x), .o_y(rot_y)
    );

    // CORDIC gain compensation
    mwo_sermul #(.A_W(mwo_pkg::CRD_W), .B_W(mwo_pkg::GAIN_W), .P_W(mwo_pkg::GAIN_P_W),
                 .B_SIGNED(1'b0)) u_gain_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == mwo_pkg::ST_ROT && rot_done),
        .i_a(rot_x), .i_b(mwo_pkg::GAIN_Q30), .o_done(gain_done_x), .o_p(gain_px)
    );
    mwo_sermul #(.A_W(mwo_pkg::CRD_W), .B_W(mwo_pkg::GAIN_W), .P_W(mwo_pkg::GAIN_P_W),
                 .B_SIGNED(1'b0)) u_gain_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == mwo_pkg::ST_ROT && rot_done),
        .i_a(rot_y), .i_b(mwo_pkg::GAIN_Q30), .o_done(gain_done_y), .o_p(gain_py)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == mwo_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mwo_pkg::ST_DONE && out_free) begin
            r_ox <= r_pos_x;
            r_oy <= r_pos_y;
            r_oh <= r_head;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_x_position    = r_ox;
    assign o_y_position    = r_oy;
    assign o_heading_angle = r_oh;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "accept while busy")
    `ASSERT_IMPLIES(a_kin_lockstep, i_clk, i_rst_n, kin_done_x, kin_done_y && kin_done_w, "skew")
    `ASSERT_IMPLIES(a_gain_lockstep, i_clk, i_rst_n, gain_done_x, gain_done_y, "gain skew")
    `ASSERT_IMPLIES(a_rot_in_state, i_clk, i_rst_n, rot_done, r_state == mwo_pkg::ST_ROT, "stray rot")

endmodule

/* dv/odometry_pose_checker.sv */
`timescale 1ns / 1ps

module odometry_pose_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mwo_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_operation,
    input  logic [mwo_pkg::ENC_W-1:0]          i_enc_front_left,
    input  logic [mwo_pkg::ENC_W-1:0]          i_enc_front_right,
    input  logic [mwo_pkg::ENC_W-1:0]          i_enc_rear_left,
    input  logic [mwo_pkg::ENC_W-1:0]          i_enc_rear_right,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [mwo_pkg::POS_W-1:0]   i_x_position,
    input  logic signed [mwo_pkg::POS_W-1:0]   i_y_position,
    input  logic signed [mwo_pkg::ANG_W-1:0]   i_heading_angle,
    output int                                 o_errors,
    output int                                 o_pending
);
    import mwo_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ANG_W-1:0] h;
    } t_pose;

    // atan(2^-i), 2^-32 turn
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };
    localparam logic [63:0] GAIN_64 = 64'd652032875;

    t_pose            pose_q [$];
    logic [ENC_W-1:0] prev_cnt [4];
    logic [POS_W-1:0] pos_x, pos_y;
    logic [ANG_W-1:0] head;
    logic [CFG_W-1:0] dist_per_count, yaw_gain;

    assign o_pending = pose_q.size();

    // step scaled by a register, floor /2^16
    function automatic logic [63:0] scale_step(input int s, input logic [31:0] g);
        logic [63:0] p;
        p = 64'(longint'(s)) * {32'd0, g};
        return 64'($signed(p) >>> 16);
    endfunction

    task automatic rotate_step(input logic [63:0] xi, input logic [63:0] yi,
                               input logic [31:0] h, output logic [63:0] xo,
                               output logic [63:0] yo);
        logic [63:0] x, y, xs, ys, p;
        longint      z;
        x = xi;
        y = yi;
        if (h[31:30] == 2'b01 || h[31:30] == 2'b10) begin
            x = -x;
            y = -y;
            h = h + 32'h8000_0000;
        end
        z = longint'($signed(h));
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = 64'($signed(x) >>> i);
            ys = 64'($signed(y) >>> i);
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURN[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURN[i]);
            end
        end
        p  = x * GAIN_64;
        xo = 64'($signed(p) >>> 32);
        p  = y * GAIN_64;
        yo = 64'($signed(p) >>> 32);
    endtask

    task automatic advance_pose(input logic op, input logic [ENC_W-1:0] cnt [4]);
        int          d [4];
        int          sx, sy, sw;
        logic [63:0] vx, vy, gx, gy, dth;
        t_pose       r;
        if (op == OP_CAPTURE) begin
            prev_cnt = cnt;
            pos_x = '0;
            pos_y = '0;
            head = '0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                d[i] = int'(cnt[i]) - int'(prev_cnt[i]);
                if (d[i] > COUNTS_PER_REV / 2)
                    d[i] -= COUNTS_PER_REV;
                else if (d[i] < -(COUNTS_PER_REV / 2))
                    d[i] += COUNTS_PER_REV;
                prev_cnt[i] = cnt[i];
            end
            sx = d[0] + d[1] + d[2] + d[3];
            sy = -d[0] + d[1] + d[2] - d[3];
            sw = -d[0] + d[1] - d[2] + d[3];
            vx = scale_step(sx, dist_per_count);
            vy = scale_step(sy, dist_per_count);
            rotate_step(vx, vy, head, gx, gy);
            pos_x = pos_x + gx[POS_W-1:0];
            pos_y = pos_y + gy[POS_W-1:0];
            dth = scale_step(sw, yaw_gain);
            head = head + dth[31:0];
        end
        r.x = pos_x;
        r.y = pos_y;
        r.h = head;
        pose_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_pose            e;
        logic [ENC_W-1:0] cnt [4];
        if (!i_rst_n) begin
            prev_cnt = '{default: '0};
            pos_x = '0;
            pos_y = '0;
            head = '0;
            dist_per_count = '0;
            yaw_gain = '0;
            pose_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: x=%h y=%h h=%h",
                             $time, i_x_position, i_y_position, i_heading_angle);
                    o_errors++;
                end else begin
                    e = pose_q.pop_front();
                    if (i_x_position !== e.x) begin
                        $display("%0t: x mismatch exp=%h act=%h", $time, e.x, i_x_position);
                        o_errors++;
                    end
                    if (i_y_position !== e.y) begin
                        $display("%0t: y mismatch exp=%h act=%h", $time, e.y, i_y_position);
                        o_errors++;
                    end
                    if (i_heading_angle !== e.h) begin
                        $display("%0t: heading mismatch exp=%h act=%h", $time, e.h,
                                 i_heading_angle);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                cnt = '{i_enc_front_left, i_enc_front_right, i_enc_rear_left,
                        i_enc_rear_right};
                advance_pose(i_operation, cnt);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DIST)
                    dist_per_count = i_cfg_data;
                else if (i_cfg_index == CFG_YAW)
                    yaw_gain = i_cfg_data;
            end
        end
    end
endmodule

/* dv/tb_mecanum_wheel_odometry_top.sv */
`timescale 1ns / 1ps

module tb_mecanum_wheel_odometry_top;
    import mwo_pkg::*;

    localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 185;
    localparam int DRAIN_CYCLES = 80;    // settling margin after the last expected result

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_operation = OP_CAPTURE;
    logic [ENC_W-1:0]        i_enc_front_left = '0;
    logic [ENC_W-1:0]        i_enc_front_right = '0;
    logic [ENC_W-1:0]        i_enc_rear_left = '0;
    logic [ENC_W-1:0]        i_enc_rear_right = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [POS_W-1:0] o_x_position, o_y_position;
    logic signed [ANG_W-1:0] o_heading_angle;

    int errors, pending;
    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    logic [ENC_W-1:0] wheel_pos [4];   // stimulus' own idea of the encoders

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mecanum_wheel_odometry_top uut (.*);

    odometry_pose_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_operation,
        .i_enc_front_left, .i_enc_front_right, .i_enc_rear_left, .i_enc_rear_right,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_x_position(o_x_position), .i_y_position(o_y_position),
        .i_heading_angle(o_heading_angle),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Called at a falling edge, returns at a falling edge. Valid only drops when
    // the sender idles, so back-to-back words keep it high throughout.
    task automatic send_word(input logic op, input logic [ENC_W-1:0] c [4]);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_operation       <= op;
        i_enc_front_left  <= c[0];
        i_enc_front_right <= c[1];
        i_enc_rear_left   <= c[2];
        i_enc_rear_right  <= c[3];
        i_in_valid        <= 1'b1;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
        wheel_pos = c;
    endtask

    // quiesce: nothing in flight, then let the pipeline settle
    task automatic drain;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly plausible wheel motion, sometimes a jump near or past half a rev
    function automatic logic [ENC_W-1:0] next_count(input logic [ENC_W-1:0] p);
        int r;
        r = $urandom_range(9);
        if (r <= 5)
            return p + ENC_W'($urandom_range(128) - 64);
        else if (r <= 7)
            return p + ENC_W'($urandom_range(8192) - 4096);
        else if (r == 8)
            return ENC_W'($urandom);
        return p;
    endfunction

    initial begin
        logic [ENC_W-1:0] c [4];
        logic [CFG_W-1:0] dpc, yg;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // update with no prior capture: deltas against zero counts, gains still zero
        send_word(OP_UPDATE, '{13'd100, 13'd8000, 13'd5, 13'd4096});
        drain();
        write_reg(CFG_DIST, 32'h0040_0000);
        write_reg(CFG_YAW, 32'h0800_0000);

        // directed: captures at both ends, half-rev boundaries, wrap just past them
        send_word(OP_CAPTURE, '{default: 13'd0});
        send_word(OP_UPDATE, '{13'd4096, 13'd4096, 13'd4096, 13'd4096});
        send_word(OP_UPDATE, '{13'd0, 13'd0, 13'd0, 13'd0});
        send_word(OP_UPDATE, '{13'd4097, 13'd8191, 13'd4095, 13'd1});
        send_word(OP_CAPTURE, '{default: 13'd8191});
        send_word(OP_UPDATE, '{13'd0, 13'd0, 13'd0, 13'd0});
        send_word(OP_UPDATE, '{13'd4095, 13'd4094, 13'd4097, 13'd4096});
        // pure yaw, then pure strafe
        for (int k = 0; k < 6; k++)
            send_word(OP_UPDATE, '{wheel_pos[0] - 13'd600, wheel_pos[1] + 13'd600,
                                   wheel_pos[2] - 13'd600, wheel_pos[3] + 13'd600});
        for (int k = 0; k < 4; k++)
            send_word(OP_UPDATE, '{wheel_pos[0] - 13'd300, wheel_pos[1] + 13'd300,
                                   wheel_pos[2] + 13'd300, wheel_pos[3] - 13'd300});
        send_word(OP_CAPTURE, '{13'd1234, 13'd7, 13'd8190, 13'd4096});
        send_word(OP_UPDATE, '{13'd1234, 13'd7, 13'd8190, 13'd4096});
        drain();   // full pause before the random part

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin dpc = 32'hFFFF_FFFF; yg = 32'hFFFF_FFFF; end
                1: begin dpc = 32'd0;         yg = 32'd0;         end
                2: begin dpc = 32'h0010_0000 + $urandom_range(65535);
                         yg  = $urandom_range(32'h0400_0000); end
                default: begin dpc = $urandom; yg = $urandom; end
            endcase
            write_reg(CFG_DIST, dpc);
            write_reg(CFG_YAW, yg);
            case ((ph + ph / 4) % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin send_idle_pct = 9; rx_stall_pct = 9; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 3) begin
                    // noise: arbitrary counts, either operation
                    for (int w = 0; w < 4; w++)
                        c[w] = ENC_W'($urandom);
                    send_word(1'($urandom), c);
                end else begin
                    for (int w = 0; w < 4; w++)
                        c[w] = next_count(wheel_pos[w]);
                    send_word(($urandom_range(99) < 8) ? OP_CAPTURE : OP_UPDATE, c);
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
